// ===== rtl/tdtt_pkg.sv =====
// Shared types and constants for the task delay tick timers block.
package tdtt_pkg;

   localparam int TASK_COUNT_DEF = 32;   // default number of task timers
   localparam int TICK_MS_DEF    = 2;    // default tick period in ms

   localparam int CNT_W   = 17;          // countdown width
   localparam int HOG_W   = 16;          // exclusive-mode tick counter width
   localparam int TASK_W  = 5;           // task id field width
   localparam int DELAY_W = 16;          // delay field width

   localparam logic [HOG_W-1:0] HOG_LIMIT_RST = 16'd500;

   // Input word kinds (req_tuser)
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SET  = 1'b1;

   // Result word kinds (rsp_tuser)
   localparam logic EV_WAKE    = 1'b0;
   localparam logic EV_RELEASE = 1'b1;

   // Write request into the countdown store
   typedef struct packed {
      logic             en;
      logic [CNT_W-1:0] data;
   } cnt_wr_type;

endpackage

// ===== rtl/tdtt_cnt_mem.sv =====
// Countdown store: one counter per task, valid bits model the all-zero reset.
module tdtt_cnt_mem
   import tdtt_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF,
   parameter int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  cnt_wr_type       wr,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [CNT_W-1:0] rd_data
);

   logic [CNT_W-1:0]      mem [TASK_COUNT];
   logic [TASK_COUNT-1:0] valid_ff;
   logic [CNT_W-1:0]      rd_data_ff;

   // Hold written counts; a never-written entry reads as zero
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/task_delay_tick_timers_core.sv =====
// Top level: per-task countdown timers with an exclusive-mode release counter.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------------------
//  req_     | in        | req_tvalid/req_tready | tuser kind, tdata task/delay/hog flag
//  rsp_     | out       | rsp_tvalid/rsp_tready | tuser event kind, tdata task, tlast
//  csr_     | in        | csr_wr_en             | csr_wr_data = hog limit
//
// A set-delay word is written to the store as it is accepted, leaves the block idle and gives no result.
// A tick word runs through the states in order: the accepting cycle fetches the
// first counter, then S_SCAN takes one task per cycle (unless a stalled output
// holds it) through the shared decrement/compare unit, which reads the next
// counter from the store while it writes back the current one, then S_HOG
// updates the release counter and S_FLUSH sends the last result.
// Reset clears every countdown (through the store's valid bits), the release
// counter and the output; the hog limit returns to 500.
// A stalled output holds the scan only when a second result is waiting.
module task_delay_tick_timers_core
   import tdtt_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF,
   parameter int TICK_MS    = TICK_MS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // req: tuser = kind
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,
   // tdata: [4:0] task_id, [20:5] delay in ms, [21] hog_flag, [23:22] zero
   input  logic [23:0]      req_tdata,
   // rsp: tuser = event_kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_tuser,
   // tdata: [4:0] woken_task, [7:5] zero
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   // hog limit register
   input  logic             csr_wr_en,
   input  logic [HOG_W-1:0] csr_wr_data
);

   localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_COUNT - 1);

   // Divide by the tick period through a reciprocal multiply; the rounded-up
   // reciprocal with this shift is exact for every 16-bit delay and any tick
   // period up to 32
   localparam int RECIP_SH = DELAY_W + 5;
   localparam int PROD_W   = DELAY_W + RECIP_SH;
   localparam logic [RECIP_SH:0] RECIP_MUL =
      (RECIP_SH+1)'(((1 << RECIP_SH) + TICK_MS - 1) / TICK_MS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_HOG,
      S_FLUSH
   } state_type;

   // Unpack the request word
   logic [TASK_W-1:0]  req_task;
   logic [DELAY_W-1:0] req_delay;
   logic               req_hog;

   assign req_task  = req_tdata[TASK_W-1:0];
   assign req_delay = req_tdata[TASK_W+DELAY_W-1:TASK_W];
   assign req_hog   = req_tdata[TASK_W+DELAY_W];

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               flag_ff, flag_in;
   logic [HOG_W-1:0]   hog_ff, hog_in;
   logic [HOG_W-1:0]   limit_ff, limit_in;
   logic               pend_vld_ff, pend_vld_in;
   logic               pend_kind_ff, pend_kind_in;
   logic [TASK_W-1:0]  pend_task_ff, pend_task_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [TASK_W-1:0]  rsp_task_ff, rsp_task_in;
   logic               rsp_last_ff, rsp_last_in;

   cnt_wr_type         wr;
   logic [IDX_W-1:0]   wr_addr;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [CNT_W-1:0]   rd_data;

   // Shared unit: decrement and zero test of the counter under scan
   logic [CNT_W-1:0]   cnt_dec;
   logic               cnt_busy;
   logic               cnt_hit;
   logic [HOG_W-1:0]   hog_inc;
   logic               hog_rel;
   logic               out_free;
   logic [PROD_W-1:0]  delay_prod;
   logic [CNT_W-1:0]   delay_load;

   assign cnt_dec  = rd_data - CNT_W'(1);
   assign cnt_busy = (rd_data != '0);
   assign cnt_hit  = cnt_busy && (cnt_dec == '0);
   assign hog_inc  = hog_ff + HOG_W'(1);
   assign hog_rel  = flag_ff && (hog_inc >= limit_ff);
   assign out_free = !rsp_vld_ff || rsp_tready;

   // Ticks per requested delay, plus one so a short delay wakes on the next tick
   assign delay_prod = PROD_W'(req_delay) * PROD_W'(RECIP_MUL);
   assign delay_load = CNT_W'(delay_prod[PROD_W-1:RECIP_SH]) + CNT_W'(1);

   tdtt_cnt_mem #(
      .TASK_COUNT (TASK_COUNT),
      .IDX_W      (IDX_W)
   ) u_cnt_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      flag_in      = flag_ff;
      hog_in       = hog_ff;
      limit_in     = limit_ff;
      pend_vld_in  = pend_vld_ff;
      pend_kind_in = pend_kind_ff;
      pend_task_in = pend_task_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_last_in  = rsp_last_ff;
      wr.en        = 1'b0;
      wr.data      = '0;
      wr_addr      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      // Drop the output word once taken
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == KIND_SET) begin
                  // Ignore tasks beyond the configured count
                  if (32'(req_task) < TASK_COUNT) begin
                     wr.en   = 1'b1;
                     wr.data = delay_load;
                     wr_addr = IDX_W'(req_task);
                  end
               end else begin
                  // Start the scan: fetch the first counter now
                  idx_in      = '0;
                  flag_in     = req_hog;
                  pend_vld_in = 1'b0;
                  rd_en       = 1'b1;
                  rd_addr     = '0;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Hold when a new wake meets a full output and a waiting result
            if (!(cnt_hit && pend_vld_ff && !out_free)) begin
               if (cnt_busy) begin
                  wr.en   = 1'b1;
                  wr.data = cnt_dec;
                  wr_addr = idx_ff;
               end
               if (cnt_hit) begin
                  if (pend_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_kind_in = pend_kind_ff;
                     rsp_task_in = pend_task_ff;
                     rsp_last_in = 1'b0;
                  end
                  pend_vld_in  = 1'b1;
                  pend_kind_in = EV_WAKE;
                  pend_task_in = TASK_W'(idx_ff);
               end
               if (idx_ff == IDX_LAST) begin
                  state_in = S_HOG;
               end else begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end
         S_HOG: begin
            if (!(hog_rel && pend_vld_ff && !out_free)) begin
               if (!flag_ff || hog_rel) begin
                  hog_in = '0;
               end else begin
                  hog_in = hog_inc;
               end
               if (hog_rel) begin
                  if (pend_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_kind_in = pend_kind_ff;
                     rsp_task_in = pend_task_ff;
                     rsp_last_in = 1'b0;
                  end
                  pend_vld_in  = 1'b1;
                  pend_kind_in = EV_RELEASE;
                  pend_task_in = '0;
               end
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            // Send the held result as the tick's last word
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = pend_kind_ff;
               rsp_task_in = pend_task_ff;
               rsp_last_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         hog_ff      <= '0;
         limit_ff    <= HOG_LIMIT_RST;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         hog_ff      <= hog_in;
         limit_ff    <= limit_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      idx_ff       <= idx_in;
      flag_ff      <= flag_in;
      pend_kind_ff <= pend_kind_in;
      pend_task_ff <= pend_task_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {3'b000, rsp_task_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== dv/task_delay_tick_timers_core_tb.sv =====
// Self-checking testbench for the per-task countdown timers with exclusive-mode release.
`timescale 1ns / 1ps

module task_delay_tick_timers_core_tb
   import tdtt_pkg::*;
();

   localparam int CLK_HALF     = 5;
   // A tick word scans every task; allow two scans plus margin
   // before touching the hog limit register once the result queue is empty.
   localparam int SCAN_SLACK   = 2 * (TASK_COUNT_DEF + 3) + 10;
   localparam int LIMIT_CYCLES = 300000;
   localparam int HOLD_CYCLES  = 600;

   // One input word, fields as the block sees them.
   typedef struct packed {
      logic              kind;
      logic [TASK_W-1:0]  task_id;
      logic [DELAY_W-1:0] delay_val;
      logic              hog_flag;
   } timer_word_type;

   // One result word.
   typedef struct packed {
      logic              event_kind;
      logic [TASK_W-1:0] woken_task;
      logic              last;
   } timer_event_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic             req_tuser   = 1'b0;
   logic [23:0]      req_tdata   = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic             rsp_tuser;
   logic [7:0]       rsp_tdata;
   logic             rsp_tlast;
   logic             csr_wr_en   = 1'b0;
   logic [HOG_W-1:0] csr_wr_data = '0;

   // Shadow state of the timers, updated at each accepted word.
   logic [CNT_W-1:0] countdown_model [TASK_COUNT_DEF];
   logic [HOG_W-1:0] hog_ticks_model;
   logic [HOG_W-1:0] hog_limit_model;

   timer_word_type  pending_words[$];
   timer_event_type expected_events[$];
   timer_word_type  offered_word;
   logic         req_took      = 1'b0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           hold_starts   = 0;   // bumped by the stimulus to start a long hold-off
   int           hold_seen     = 0;
   int           rsp_hold_left = 0;
   int           mismatch_count = 0;
   int           cycle_count    = 0;

   task_delay_tick_timers_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Apply one accepted word to the shadow timers and queue the events it causes.
   function automatic void advance_timers(timer_word_type w);
      timer_event_type ev;
      int              first_new;
      first_new = expected_events.size();
      if (w.kind == KIND_SET) begin
         // Reload overwrites whatever is running; short delays load 1.
         if (w.task_id < TASK_COUNT_DEF)
            countdown_model[w.task_id] = CNT_W'(w.delay_val / TICK_MS_DEF) + 1'b1;
         return;
      end
      for (int i = 0; i < TASK_COUNT_DEF; i++) begin
         if (countdown_model[i] != '0) begin
            countdown_model[i] = countdown_model[i] - 1'b1;
            if (countdown_model[i] == '0) begin
               ev.event_kind = EV_WAKE;
               ev.woken_task = TASK_W'(i);
               ev.last       = 1'b0;
               expected_events.push_back(ev);
            end
         end
      end
      if (w.hog_flag) begin
         hog_ticks_model = hog_ticks_model + 1'b1;
         // Compare with >= so a freshly lowered limit releases at once.
         if (hog_ticks_model >= hog_limit_model) begin
            hog_ticks_model = '0;
            ev.event_kind = EV_RELEASE;
            ev.woken_task = '0;
            ev.last       = 1'b0;
            expected_events.push_back(ev);
         end
      end else begin
         hog_ticks_model = '0;
      end
      // Mark the final event of this tick; a quiet tick queues nothing.
      if (expected_events.size() > first_new) begin
         ev = expected_events.pop_back();
         ev.last = 1'b1;
         expected_events.push_back(ev);
      end
   endfunction

   // Input side at the rising edge: track reset, register writes and accepted words.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_COUNT_DEF; i++)
            countdown_model[i] = '0;
         hog_ticks_model = '0;
         hog_limit_model = HOG_LIMIT_RST;
         req_took <= 1'b0;
      end else begin
         if (csr_wr_en)
            hog_limit_model = csr_wr_data;
         if (req_tvalid && req_tready)
            advance_timers(offered_word);
         req_took <= req_tvalid && req_tready;
      end
   end

   // Driver: hold the current word until taken, then offer the next one or idle.
   always @(negedge clock) begin
      timer_word_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_words.pop_front();
            req_tvalid   <= 1'b1;
            req_tuser    <= nxt.kind;
            req_tdata    <= {2'b00, nxt.hog_flag, nxt.delay_val, nxt.task_id};
            offered_word <= nxt;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: a long hold-off takes priority, otherwise stall at random.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_starts) begin
         hold_seen     <= hold_starts;
         rsp_hold_left <= HOLD_CYCLES - 1;
         rsp_tready    <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: compare each taken result word with the oldest expected event.
   always @(posedge clock) begin
      timer_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected result, event kind", 32'(rsp_tuser), 32'd0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser !== want.event_kind)
               report_mismatch("event kind", 32'(rsp_tuser), 32'(want.event_kind));
            if (rsp_tdata !== {3'b000, want.woken_task})
               report_mismatch("woken task", 32'(rsp_tdata), 32'(want.woken_task));
            if (rsp_tlast !== want.last)
               report_mismatch("last flag", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   // Watchdog: a hung handshake or a missing result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void push_set(int id, int delay);
      timer_word_type w;
      w.kind      = KIND_SET;
      w.task_id   = TASK_W'(id);
      w.delay_val = DELAY_W'(delay);
      w.hog_flag  = 1'($urandom_range(1));
      pending_words.push_back(w);
   endfunction

   // Ticks carry random junk in the fields they ignore.
   function automatic void push_tick(logic flag);
      timer_word_type w;
      w.kind      = KIND_TICK;
      w.task_id   = TASK_W'($urandom_range(TASK_COUNT_DEF - 1));
      w.delay_val = DELAY_W'($urandom_range(16'hFFFF));
      w.hog_flag  = flag;
      pending_words.push_back(w);
   endfunction

   // Random mix: mostly short delays so wakes come often, a few long ones.
   function automatic void push_random(int n, int hog_pct);
      int pick;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(99) < 45) begin
            pick = $urandom_range(99);
            if (pick < 85)
               push_set($urandom_range(TASK_COUNT_DEF - 1), $urandom_range(24));
            else if (pick < 95)
               push_set($urandom_range(TASK_COUNT_DEF - 1), $urandom_range(16'hFFFF));
            else
               push_set($urandom_range(TASK_COUNT_DEF - 1), 16'hFFFF - $urandom_range(3));
         end else begin
            push_tick($urandom_range(99) < hog_pct);
         end
      end
   endfunction

   // Block until every word is taken and every event has come, then let any
   // scan that produces nothing run out.
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_tvalid || expected_events.size() != 0)
         @(posedge clock);
      repeat (SCAN_SLACK) @(posedge clock);
   endtask

   // Write the hog limit while the block is idle; return aligned to a rising edge.
   task automatic write_hog_limit(input logic [HOG_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, short and long delays, reload, quiet tick.
      write_hog_limit(16'd1);
      push_set(0, 0);
      push_set(TASK_COUNT_DEF - 1, 16'hFFFF);
      push_set(5, 1);
      push_set(6, 2);
      push_set(7, 3);
      push_tick(1'b1);
      push_tick(1'b0);
      push_set(5, 10);
      push_set(5, 0);
      push_tick(1'b0);
      push_tick(1'b0);
      push_set(TASK_COUNT_DEF - 1, 16'hFFFE);
      push_set(16, 4);
      push_set(10, 5);
      push_tick(1'b1);
      push_tick(1'b1);
      push_tick(1'b1);

      // Zero limit: release on every hog tick; fire every task in one tick
      // for the largest burst of results. No idling on either side.
      write_hog_limit(16'd0);
      for (int i = 0; i < TASK_COUNT_DEF; i++)
         push_set(i, $urandom_range(1));
      push_tick(1'b1);
      push_random(24, 60);

      // Top limit: no release, hog counter builds up. Sender idles.
      write_hog_limit(16'hFFFF);
      send_idle_pct = 62;
      push_random(30, 90);
      repeat (6) push_tick(1'b1);

      // Lowered limit below the running hog count; receiver stalls and first
      // holds off long enough that the block backs up its input.
      write_hog_limit(16'd3);
      send_idle_pct = 0;
      rsp_stall_pct = 62;
      hold_starts++;
      push_tick(1'b1);
      for (int i = 0; i < 6; i++)
         push_set($urandom_range(TASK_COUNT_DEF - 1), 0);
      push_random(34, 80);

      // Small random limit, both sides idle now and then.
      write_hog_limit(HOG_W'($urandom_range(1, 8)));
      send_idle_pct = 18;
      rsp_stall_pct = 18;
      push_random(24, 75);

      wait_idle();
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
